// ----- hdl/hbn_pkg.sv -----
// hbn_pkg: shared types, widths and codes for the box hit normal and uv block
// no dependencies; used by hbn_setup, hbn_div_pipe users and the top level
package hbn_pkg;

  localparam int CW     = 21;          // one packed Q10.10 component
  localparam int VW     = 63;          // packed x,y,z vector
  localparam int TW     = 32;          // hit distance
  localparam int TOLW   = 10;
  localparam int RELW   = 22;          // hit point minus origin
  localparam int PRODW  = 43;          // rel * edge component
  localparam int DOTW   = 45;          // rel . edge
  localparam int ADW    = 44;          // |rel . edge|
  localparam int NRMW   = 16;          // Q1.14 normal component
  localparam int RAYPW  = 37;          // ray * normal component
  localparam int RDW    = 39;          // ray . normal
  localparam int LENW   = 21;          // floor of edge length
  localparam int EEW    = 42;          // edge . edge
  localparam int CRDW   = 16;          // Q0.16 surface coordinate
  localparam int PROJ_Q = 24;          // quotient bits of the projection divide
  localparam int COORD_Q = 16;         // quotient bits of the coordinate divide
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 64;

  localparam logic [CFG_IW-1:0] REG_ORIGIN = 3'd0;
  localparam logic [CFG_IW-1:0] REG_EDGE_A = 3'd1;
  localparam logic [CFG_IW-1:0] REG_EDGE_B = 3'd2;
  localparam logic [CFG_IW-1:0] REG_EDGE_C = 3'd3;
  localparam logic [CFG_IW-1:0] REG_TOL    = 3'd4;

  localparam logic [2:0] FACE_PA = 3'd0;
  localparam logic [2:0] FACE_NA = 3'd1;
  localparam logic [2:0] FACE_PB = 3'd2;
  localparam logic [2:0] FACE_NB = 3'd3;
  localparam logic [2:0] FACE_PC = 3'd4;
  localparam logic [2:0] FACE_NC = 3'd5;

  localparam logic [VW-1:0]   ORIGIN_RST = 63'd0;
  localparam logic [VW-1:0]   EDGE_A_RST = 63'd1024;
  localparam logic [VW-1:0]   EDGE_B_RST = 63'h0000_0000_8000_0000;
  localparam logic [VW-1:0]   EDGE_C_RST = 63'h0010_0000_0000_0000;
  localparam logic [TOLW-1:0] TOL_RST    = 10'd1;

  typedef struct packed {
    logic [VW-1:0] hit_point;
    logic [VW-1:0] ray_dir;
    logic [TW-1:0] hit_distance;
  } in_word_t;

  typedef struct packed {
    logic signed [NRMW-1:0] normal_x;
    logic signed [NRMW-1:0] normal_y;
    logic signed [NRMW-1:0] normal_z;
    logic [CRDW-1:0]        coord_u;
    logic [CRDW-1:0]        coord_v;
    logic                   front_face;
    logic [2:0]             face_index;
    logic                   face_found;
    logic [VW-1:0]          hit_position;
    logic [TW-1:0]          hit_time;
  } out_word_t;

  // box geometry plus values derived from the edges
  typedef struct packed {
    logic [VW-1:0]                  origin;
    logic [2:0][VW-1:0]             edge_v;
    logic [TOLW-1:0]                tol;
    logic [2:0][LENW-1:0]           len;
    logic [2:0][EEW-1:0]            ee;
    logic [2:0][2:0][NRMW-1:0]      nrm;
  } geom_t;

  function automatic logic signed [CW-1:0] vcomp(input logic [VW-1:0] w, input logic [1:0] i);
    logic signed [CW-1:0] c;
    unique case (i)
      2'd0:    c = $signed(w[CW-1:0]);
      2'd1:    c = $signed(w[2*CW-1:CW]);
      default: c = $signed(w[3*CW-1:2*CW]);
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/hbn_div_pipe.sv -----
// hbn_div_pipe: unsigned restoring divider, one quotient bit per register stage
// no package dependencies; quotient must fit in QW bits
module hbn_div_pipe #(
  parameter int NW = 44,
  parameter int DW = 21,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [QW-1:0] quotient
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   rs;
    logic [DW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = DW'(dividend[NW-1:QW]);
      assign lo_in  = dividend[QW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign lo_in  = lo_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign rs   = {rem_in, lo_in[QW-1]};
    assign ge   = rs >= {1'b0, divisor};
    assign diff = rs - {1'b0, divisor};

    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? diff[DW-1:0] : rs[DW-1:0];
      lo_r[s]  <= lo_in << 1;
      quo_r[s] <= {quo_in[QW-2:0], ge};
    end
  end

  assign quotient = quo_r[QW-1];

endmodule

// ----- hdl/hbn_setup.sv -----
// hbn_setup: configuration registers and serial set-up of edge lengths and unit normals
// depends on hbn_pkg
module hbn_setup (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hbn_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [hbn_pkg::CFG_DW-1:0]  cfg_wdata,
  output hbn_pkg::geom_t              geom,
  output logic                        busy
);
  import hbn_pkg::*;

  localparam int SQW  = EEW + 1;
  localparam int SQBW = EEW - 1;
  localparam int DQW  = NRMW - 1;
  localparam int DCW  = 4;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQ    = 3'd1;
  localparam logic [2:0] ST_ROOT  = 3'd2;
  localparam logic [2:0] ST_DIVLD = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;

  logic [VW-1:0]        origin_r;
  logic [2:0][VW-1:0]   edge_r;
  logic [TOLW-1:0]      tol_r;
  logic [2:0][LENW-1:0] len_r, len_nxt;
  logic [2:0][EEW-1:0]  ee_r, ee_nxt;
  logic [2:0][2:0][NRMW-1:0] nrm_r, nrm_nxt;

  logic [2:0]      state_r, state_nxt;
  logic [1:0]      k_r, k_nxt;
  logic [1:0]      j_r, j_nxt;
  logic [EEW-1:0]  acc_r, acc_nxt;
  logic [SQW-1:0]  sq_n_r, sq_n_nxt;
  logic [SQW-1:0]  sq_res_r, sq_res_nxt;
  logic [SQBW-1:0] sq_bit_r, sq_bit_nxt;
  logic [LENW-1:0] dv_rem_r, dv_rem_nxt;
  logic [DQW-1:0]  dv_lo_r, dv_lo_nxt;
  logic [DQW-1:0]  dv_q_r, dv_q_nxt;
  logic            dv_neg_r, dv_neg_nxt;
  logic [DCW-1:0]  dv_cnt_r, dv_cnt_nxt;

  logic                  wr;
  logic                  restart;
  logic signed [CW-1:0]  c;
  logic signed [2*CW-1:0] csq;
  logic [CW-1:0]         c_mag;
  logic [SQW-1:0]        sq_try;
  logic                  sq_ge;
  logic [LENW:0]         dv_rs;
  logic [LENW:0]         dv_diff;
  logic                  dv_ge;
  logic [DQW-1:0]        q_fin;
  logic                  next_edge;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign restart   = wr && (cfg_index == REG_EDGE_A || cfg_index == REG_EDGE_B ||
                            cfg_index == REG_EDGE_C);
  assign busy      = state_r != ST_IDLE;

  assign c       = vcomp(edge_r[k_r], j_r);
  assign csq     = c * c;
  assign c_mag   = c[CW-1] ? CW'(-c) : CW'(c);
  assign sq_try  = sq_res_r + SQW'(sq_bit_r);
  assign sq_ge   = sq_n_r >= sq_try;
  assign dv_rs   = {dv_rem_r, dv_lo_r[DQW-1]};
  assign dv_ge   = dv_rs >= {1'b0, len_r[k_r]};
  assign dv_diff = dv_rs - {1'b0, len_r[k_r]};
  assign q_fin   = {dv_q_r[DQW-2:0], dv_ge};

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    acc_nxt    = acc_r;
    sq_n_nxt   = sq_n_r;
    sq_res_nxt = sq_res_r;
    sq_bit_nxt = sq_bit_r;
    dv_rem_nxt = dv_rem_r;
    dv_lo_nxt  = dv_lo_r;
    dv_q_nxt   = dv_q_r;
    dv_neg_nxt = dv_neg_r;
    dv_cnt_nxt = dv_cnt_r;
    len_nxt    = len_r;
    ee_nxt     = ee_r;
    nrm_nxt    = nrm_r;
    next_edge  = 1'b0;

    unique case (state_r)
      ST_SQ: begin
        acc_nxt = acc_r + EEW'(unsigned'(csq));
        if (j_r == 2'd2) begin
          ee_nxt[k_r] = acc_nxt;
          sq_n_nxt    = SQW'(acc_nxt);
          sq_res_nxt  = '0;
          sq_bit_nxt  = SQBW'(1) << (SQBW - 1);
          j_nxt       = 2'd0;
          state_nxt   = ST_ROOT;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_ROOT: begin
        if (sq_ge) begin
          sq_n_nxt   = sq_n_r - sq_try;
          sq_res_nxt = (sq_res_r >> 1) + SQW'(sq_bit_r);
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        if (sq_bit_r == SQBW'(1)) begin
          len_nxt[k_r] = sq_res_nxt[LENW-1:0];
          if (sq_res_nxt == '0) begin
            nrm_nxt[k_r] = '0;
            next_edge    = 1'b1;
          end else begin
            state_nxt = ST_DIVLD;
          end
        end
      end
      ST_DIVLD: begin
        // magnitude * 2^14, top bits go straight into the remainder
        dv_rem_nxt = LENW'(c_mag[CW-1:1]);
        dv_lo_nxt  = {c_mag[0], {(DQW-1){1'b0}}};
        dv_q_nxt   = '0;
        dv_neg_nxt = c[CW-1];
        dv_cnt_nxt = '0;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        dv_rem_nxt = dv_ge ? dv_diff[LENW-1:0] : dv_rs[LENW-1:0];
        dv_lo_nxt  = dv_lo_r << 1;
        dv_q_nxt   = q_fin;
        dv_cnt_nxt = dv_cnt_r + DCW'(1);
        if (dv_cnt_r == DCW'(DQW - 1)) begin
          nrm_nxt[k_r][j_r] = dv_neg_r ? -NRMW'(q_fin) : NRMW'(q_fin);
          if (j_r == 2'd2) begin
            next_edge = 1'b1;
          end else begin
            j_nxt     = j_r + 2'd1;
            state_nxt = ST_DIVLD;
          end
        end
      end
      default: begin
      end
    endcase

    if (next_edge) begin
      j_nxt   = 2'd0;
      acc_nxt = '0;
      if (k_r == 2'd2) begin
        state_nxt = ST_IDLE;
      end else begin
        k_nxt     = k_r + 2'd1;
        state_nxt = ST_SQ;
      end
    end

    if (restart) begin
      state_nxt = ST_SQ;
      k_nxt     = 2'd0;
      j_nxt     = 2'd0;
      acc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r  <= ORIGIN_RST;
      edge_r[0] <= EDGE_A_RST;
      edge_r[1] <= EDGE_B_RST;
      edge_r[2] <= EDGE_C_RST;
      tol_r     <= TOL_RST;
      state_r   <= ST_SQ;
      k_r       <= 2'd0;
      j_r       <= 2'd0;
      acc_r     <= '0;
    end else begin
      if (wr) begin
        unique case (cfg_index)
          REG_ORIGIN: origin_r  <= cfg_wdata[VW-1:0];
          REG_EDGE_A: edge_r[0] <= cfg_wdata[VW-1:0];
          REG_EDGE_B: edge_r[1] <= cfg_wdata[VW-1:0];
          REG_EDGE_C: edge_r[2] <= cfg_wdata[VW-1:0];
          REG_TOL:    tol_r     <= cfg_wdata[TOLW-1:0];
          default: begin
          end
        endcase
      end
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_n_r   <= sq_n_nxt;
    sq_res_r <= sq_res_nxt;
    sq_bit_r <= sq_bit_nxt;
    dv_rem_r <= dv_rem_nxt;
    dv_lo_r  <= dv_lo_nxt;
    dv_q_r   <= dv_q_nxt;
    dv_neg_r <= dv_neg_nxt;
    dv_cnt_r <= dv_cnt_nxt;
    len_r    <= len_nxt;
    ee_r     <= ee_nxt;
    nrm_r    <= nrm_nxt;
  end

  assign geom.origin = origin_r;
  assign geom.edge_v = edge_r;
  assign geom.tol    = tol_r;
  assign geom.len    = len_r;
  assign geom.ee     = ee_r;
  assign geom.nrm    = nrm_r;

  a_edge_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> busy)
    else $error("edge write did not start the set-up pass");

endmodule

// ----- hdl/box_hit_normal_and_uv.sv -----
// box_hit_normal_and_uv: top level, face pick, normal and uv of a box hit
// depends on hbn_pkg, hbn_setup, hbn_div_pipe
// throughput: one word per cycle whenever busy is low, results cannot be stalled
// reset: registers return to defaults, then busy stays high while edge lengths
//   and unit normals are rebuilt; an edge write repeats that pass
module box_hit_normal_and_uv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  hbn_pkg::in_word_t           in_data,
  output logic                        out_valid,
  output hbn_pkg::out_word_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hbn_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [hbn_pkg::CFG_DW-1:0]  cfg_wdata
);
  import hbn_pkg::*;

  localparam int PW   = PROJ_Q + 1;
  localparam int DFW  = PROJ_Q + 2;
  localparam int CDLY = PROJ_Q - COORD_Q;
  localparam int LAT  = 5 + PROJ_Q + 2;

  // side data riding along with the dividers
  typedef struct packed {
    logic [VW-1:0] hit_point;
    logic [TW-1:0] hit_distance;
    logic [2:0]    dneg;
    logic [2:0]    czero;
    logic [2:0]    csat;
    logic [2:0]    rdneg;
    logic [2:0]    rdpos;
  } side_t;

  geom_t geom;

  hbn_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .busy      (busy)
  );

  // stage 1: capture the word
  logic     s1_v_r;
  in_word_t s1_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_w_r <= in_data;
  end

  // stage 2: hit point relative to the corner
  logic                    s2_v_r;
  logic signed [RELW-1:0]  rel2_r [3];
  logic signed [CW-1:0]    ray2_r [3];
  logic [VW-1:0]           hp2_r;
  logic [TW-1:0]           ht2_r;

  // stage 3: products for rel . edge and ray . normal
  logic                    s3_v_r;
  logic signed [PRODW-1:0] prod3_r [3][3];
  logic signed [RAYPW-1:0] rp3_r   [3][3];
  logic [VW-1:0]           hp3_r;
  logic [TW-1:0]           ht3_r;

  // stage 4: dot products
  logic                    s4_v_r;
  logic signed [DOTW-1:0]  d4_r  [3];
  logic signed [RDW-1:0]   rd4_r [3];
  logic [VW-1:0]           hp4_r;
  logic [TW-1:0]           ht4_r;

  // stage 5: magnitudes and coordinate range flags
  logic                    s5_v_r;
  logic [ADW-1:0]          absd5_r [3];
  logic [EEW-1:0]          dlow5_r [3];
  side_t                   s5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      rel2_r[k] <= RELW'(vcomp(s1_w_r.hit_point, 2'(k))) - RELW'(vcomp(geom.origin, 2'(k)));
      ray2_r[k] <= vcomp(s1_w_r.ray_dir, 2'(k));
    end
    hp2_r <= s1_w_r.hit_point;
    ht2_r <= s1_w_r.hit_distance;

    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod3_r[k][j] <= rel2_r[j] * vcomp(geom.edge_v[k], 2'(j));
        rp3_r[k][j]   <= ray2_r[j] * $signed(geom.nrm[k][j]);
      end
    end
    hp3_r <= hp2_r;
    ht3_r <= ht2_r;

    for (int k = 0; k < 3; k++) begin
      d4_r[k]  <= DOTW'(prod3_r[k][0]) + DOTW'(prod3_r[k][1]) + DOTW'(prod3_r[k][2]);
      rd4_r[k] <= RDW'(rp3_r[k][0]) + RDW'(rp3_r[k][1]) + RDW'(rp3_r[k][2]);
    end
    hp4_r <= hp3_r;
    ht4_r <= ht3_r;

    for (int k = 0; k < 3; k++) begin
      absd5_r[k]         <= d4_r[k][DOTW-1] ? ADW'(-d4_r[k]) : ADW'(d4_r[k]);
      dlow5_r[k]         <= d4_r[k][EEW-1:0];
      s5_side_r.dneg[k]  <= d4_r[k][DOTW-1];
      // coordinate is zero at or behind the corner, full scale at or past the far edge
      s5_side_r.czero[k] <= (d4_r[k] <= 0) || (geom.ee[k] == '0);
      s5_side_r.csat[k]  <= d4_r[k] >= $signed({3'b000, geom.ee[k]});
      s5_side_r.rdneg[k] <= rd4_r[k] < 0;
      s5_side_r.rdpos[k] <= rd4_r[k] > 0;
    end
    s5_side_r.hit_point    <= hp4_r;
    s5_side_r.hit_distance <= ht4_r;
  end

  // divider bank: projection onto each unit edge, fraction along each edge
  logic [PROJ_Q-1:0]  projq [3];
  logic [COORD_Q-1:0] crdq  [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    hbn_div_pipe #(.NW(ADW), .DW(LENW), .QW(PROJ_Q)) u_proj (
      .clk      (clk),
      .dividend (absd5_r[k]),
      .divisor  (geom.len[k]),
      .quotient (projq[k])
    );

    hbn_div_pipe #(.NW(EEW + CRDW), .DW(EEW), .QW(COORD_Q)) u_coord (
      .clk      (clk),
      .dividend ({dlow5_r[k], {CRDW{1'b0}}}),
      .divisor  (geom.ee[k]),
      .quotient (crdq[k])
    );
  end

  side_t                    side_r [PROJ_Q];
  logic [PROJ_Q-1:0]        dv_r;
  logic [2:0][CRDW-1:0]     cq_r [CDLY];
  logic [2:0][CRDW-1:0]     cq_in;
  side_t                    side_cq;

  assign side_cq = side_r[COORD_Q-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (side_cq.czero[k]) begin
        cq_in[k] = '0;
      end else if (side_cq.csat[k]) begin
        cq_in[k] = '1;
      end else begin
        cq_in[k] = crdq[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else begin
      dv_r <= {dv_r[PROJ_Q-2:0], s5_v_r};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= s5_side_r;
    for (int s = 1; s < PROJ_Q; s++) begin
      side_r[s] <= side_r[s-1];
    end
    cq_r[0] <= cq_in;
    for (int s = 1; s < CDLY; s++) begin
      cq_r[s] <= cq_r[s-1];
    end
  end

  // stage 6: face tests against the tolerance
  side_t                side_d;
  logic signed [PW-1:0] proj6 [3];
  logic signed [DFW-1:0] dif6 [3];
  logic [DFW-1:0]       adif6 [3];
  logic [PW-1:0]        aprj6 [3];
  logic [5:0]           m6_nxt;

  logic                 s6_v_r;
  logic [5:0]           m6_r;
  side_t                s6_side_r;
  logic [2:0][CRDW-1:0] crd6_r;

  assign side_d = side_r[PROJ_Q-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      proj6[k] = side_d.dneg[k] ? -$signed({1'b0, projq[k]}) : $signed({1'b0, projq[k]});
      dif6[k]  = DFW'(proj6[k]) - DFW'($signed({1'b0, geom.len[k]}));
      adif6[k] = dif6[k][DFW-1] ? -dif6[k] : dif6[k];
      aprj6[k] = proj6[k][PW-1] ? -proj6[k] : proj6[k];
      // far face of edge k, then near face of edge k
      m6_nxt[2*k]   = (geom.len[k] != '0) && (adif6[k] < DFW'(geom.tol));
      m6_nxt[2*k+1] = (geom.len[k] != '0) && (aprj6[k] < PW'(geom.tol));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= dv_r[PROJ_Q-1];
    end
  end

  always_ff @(posedge clk) begin
    m6_r      <= m6_nxt;
    s6_side_r <= side_d;
    crd6_r    <= cq_r[CDLY-1];
  end

  // stage 7: first matching face, facing and uv selection
  logic [2:0]           face7;
  logic                 found7;
  logic [1:0]           axis7;
  logic                 odd7;
  logic                 front7;
  logic                 flip7;
  logic [1:0]           ua7;
  logic [1:0]           va7;
  logic signed [NRMW-1:0] n7 [3];
  out_word_t            out_nxt;

  always_comb begin
    found7 = |m6_r;
    priority if (m6_r[0]) begin
      face7 = FACE_PA;
    end else if (m6_r[1]) begin
      face7 = FACE_NA;
    end else if (m6_r[2]) begin
      face7 = FACE_PB;
    end else if (m6_r[3]) begin
      face7 = FACE_NB;
    end else if (m6_r[4]) begin
      face7 = FACE_PC;
    end else if (m6_r[5]) begin
      face7 = FACE_NC;
    end else begin
      face7 = FACE_PA;
    end

    axis7  = face7[2:1];
    odd7   = face7[0];
    // outward normal of a near face points against the edge
    front7 = found7 && (odd7 ? s6_side_r.rdpos[axis7] : s6_side_r.rdneg[axis7]);
    flip7  = odd7 ^ !front7;
    ua7    = (axis7 == 2'd0) ? 2'd1 : 2'd0;
    va7    = (axis7 == 2'd2) ? 2'd1 : 2'd2;

    for (int k = 0; k < 3; k++) begin
      if (!found7) begin
        n7[k] = '0;
      end else if (flip7) begin
        n7[k] = -$signed(geom.nrm[axis7][k]);
      end else begin
        n7[k] = $signed(geom.nrm[axis7][k]);
      end
    end

    out_nxt.normal_x     = n7[0];
    out_nxt.normal_y     = n7[1];
    out_nxt.normal_z     = n7[2];
    out_nxt.coord_u      = found7 ? crd6_r[ua7] : '0;
    out_nxt.coord_v      = found7 ? crd6_r[va7] : '0;
    out_nxt.front_face   = front7;
    out_nxt.face_index   = face7;
    out_nxt.face_found   = found7;
    out_nxt.hit_position = s6_side_r.hit_point;
    out_nxt.hit_time     = s6_side_r.hit_distance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_nxt;
  end

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted word did not produce a result at the expected cycle");

  a_no_face_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.face_found) |->
      (out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0 &&
       out_data.coord_u == '0 && out_data.coord_v == '0 && !out_data.front_face &&
       out_data.face_index == FACE_PA))
    else $error("result without a face carries non-zero fields");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.face_found) |-> (out_data.face_index <= FACE_NC))
    else $error("face index out of range");

endmodule
